// ----- design/rlmtf_pkg.sv -----
// ============================================================================
// Recent list move-to-front package
// Shared widths, command codes, defaults and the result record passed from
// the sequencer to the output stage.
// ============================================================================
`default_nettype none

package rlmtf_pkg;

    // Field widths of the stream payloads.
    localparam int CODE_W      = 21;
    localparam int READ_IDX_W  = 8;
    localparam int FOUND_W     = 8;
    localparam int LEN_W       = 9;

    // Packed stream widths, padded to whole bytes.
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 64;

    // Default list depth.
    localparam int DEPTH_DEF   = 256;

    // Command codes.
    localparam logic CMD_TOUCH = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // One finished result, handed from the sequencer to the output register.
    typedef struct packed {
        logic                  done;
        logic                  was_present;
        logic [FOUND_W-1:0]    found_position;
        logic                  evicted;
        logic [CODE_W-1:0]     evicted_code;
        logic                  read_valid;
        logic [CODE_W-1:0]     read_code;
        logic [LEN_W-1:0]      list_length;
    } res_t;

endpackage

`default_nettype wire

// ----- design/recent_list_move_to_front_core.sv -----
// ============================================================================
// Recent list move-to-front core
// Most-recently-used list of code points held in one synchronous memory,
// with touch (move to front) and indexed read commands.
// ============================================================================
//
//  Channel  Direction  Payload (tdata, lowest bit first)
//  -------  ---------  ---------------------------------------------------
//  s_       in         command[0], code_point[21:1], read_index[29:22]
//  m_       out        was_present, found_position, evicted, evicted_code,
//                      read_valid, read_code, list_length
//
// A touch searches the list from the front until it finds its code or has
// compared all L entries, then moves each entry in front of the hole back
// by one position, one entry per step, and writes the code at the front; a
// miss on a full list evicts the last entry. A read fetches one entry.
// The cost of each command is set by the single read and single write port
// of the entry memory, which every search and shift step goes through.
// Reset clears the list length and the sequencer; the memory keeps its data,
// which is never read before it has been written. The input side stays busy
// while a transaction is worked on, and one finished result can wait in the
// output register while the next input transaction is already being taken.
// A second finished result waits in the sequencer until that register drains.
// ============================================================================
`default_nettype none

module recent_list_move_to_front_core #(
    parameter int DEPTH = rlmtf_pkg::DEPTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input transactions.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // command[0], code_point[21:1], read_index[29:22], zeros above
    input  wire logic [rlmtf_pkg::S_TDATA_W-1:0] s_tdata,
    // Result transactions.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // was_present[0], found_position[8:1], evicted[9], evicted_code[30:10],
    // read_valid[31], read_code[52:32], list_length[61:53], zeros above
    output logic [rlmtf_pkg::M_TDATA_W-1:0]      m_tdata
);

    import rlmtf_pkg::*;

    // Address width of the memory and width of the length counter, which
    // must also hold DEPTH itself.
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    res_t                 res;
    logic                 out_free;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // The output register is free when empty or being drained this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    rlmtf_seq #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_command (s_tdata[0]),
        .in_code    (s_tdata[CODE_W:1]),
        .in_index   (s_tdata[CODE_W+READ_IDX_W:CODE_W+1]),
        .out_free   (out_free),
        .res        (res)
    );

    // Result register: loaded when the sequencer finishes and the slot is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res.done && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.done && out_free) begin
            m_tdata_reg <= M_TDATA_W'({res.list_length, res.read_code, res.read_valid,
                                       res.evicted_code, res.evicted,
                                       res.found_position, res.was_present});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- design/rlmtf_mem.sv -----
// ============================================================================
// Recent list entry memory
// Single-clock memory with one write port and one read port; read data is
// registered, so it appears in the cycle after the address.
// ============================================================================
`default_nettype none

module rlmtf_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 21
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_array [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem_array[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/rlmtf_seq.sv -----
// ============================================================================
// Recent list sequencer
// Runs the search, shift and read passes over the entry memory and keeps
// the list length.
// ============================================================================
`default_nettype none

module rlmtf_seq #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int CNT_W  = 9
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        in_command,
    input  wire logic [rlmtf_pkg::CODE_W-1:0]     in_code,
    input  wire logic [rlmtf_pkg::READ_IDX_W-1:0] in_index,
    input  wire logic                        out_free,
    output rlmtf_pkg::res_t                  res
);

    import rlmtf_pkg::*;

    // Common width for comparing and reporting positions and lengths.
    localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_SHIFT  = 5'b00100,
        ST_RDWAIT = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [ADDR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic                wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]   wr_addr_reg, wr_addr_next;
    logic                hit_reg, hit_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic                ev_reg, ev_next;
    logic [CODE_W-1:0]   evcode_reg, evcode_next;
    logic                rvalid_reg, rvalid_next;
    logic [CODE_W-1:0]   rcode_reg, rcode_next;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [CODE_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [CODE_W-1:0]   mem_rdata;

    logic [EXT_W-1:0]    idx_ext;
    logic [EXT_W-1:0]    cnt_ext;
    logic [EXT_W-1:0]    pos_ext;
    logic [CNT_W-1:0]    pend_cnt;

    assign idx_ext  = EXT_W'(in_index);
    assign cnt_ext  = EXT_W'(count_reg);
    assign pos_ext  = EXT_W'(pos_reg);
    assign pend_cnt = CNT_W'(pend_idx_reg) + CNT_W'(1);

    rlmtf_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (CODE_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        code_next     = code_reg;
        k_next        = k_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_pend_next  = wr_pend_reg;
        wr_addr_next  = wr_addr_reg;
        hit_next      = hit_reg;
        pos_next      = pos_reg;
        ev_next       = ev_reg;
        evcode_next   = evcode_reg;
        rvalid_next   = rvalid_reg;
        rcode_next    = rcode_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    hit_next    = 1'b0;
                    pos_next    = '0;
                    ev_next     = 1'b0;
                    evcode_next = '0;
                    rvalid_next = 1'b0;
                    rcode_next  = '0;
                    if (in_command == CMD_TOUCH) begin
                        code_next = in_code;
                        k_next    = '0;
                        pend_next = 1'b0;
                        if (count_reg == '0) begin
                            // Empty list: the code goes straight to the front.
                            count_next   = CNT_W'(1);
                            rd_ptr_next  = '0;
                            wr_pend_next = 1'b0;
                            state_next   = ST_SHIFT;
                        end else begin
                            state_next = ST_SEARCH;
                        end
                    end else if (idx_ext < cnt_ext) begin
                        mem_re      = 1'b1;
                        mem_raddr   = idx_ext[ADDR_W-1:0];
                        rvalid_next = 1'b1;
                        state_next  = ST_RDWAIT;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SEARCH: begin
                // One read issued per cycle; its data is compared in the next cycle.
                if (k_reg < count_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = k_reg[ADDR_W-1:0];
                    k_next    = k_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                pend_idx_next = k_reg[ADDR_W-1:0];
                if (pend_reg) begin
                    if (mem_rdata == code_reg) begin
                        hit_next     = 1'b1;
                        pos_next     = pend_idx_reg;
                        rd_ptr_next  = pend_idx_reg;
                        wr_pend_next = 1'b0;
                        state_next   = ST_SHIFT;
                    end else if (pend_cnt == count_reg) begin
                        wr_pend_next = 1'b0;
                        state_next   = ST_SHIFT;
                        if (count_reg == CNT_W'(DEPTH)) begin
                            ev_next     = 1'b1;
                            evcode_next = mem_rdata;
                            rd_ptr_next = ADDR_W'(DEPTH - 1);
                        end else begin
                            rd_ptr_next = count_reg[ADDR_W-1:0];
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                end
            end

            ST_SHIFT: begin
                // Copy entry k-1 to k from the hole down to 1, then write the front.
                if (wr_pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_addr_reg;
                    mem_wdata = mem_rdata;
                end
                if (rd_ptr_reg != '0) begin
                    mem_re       = 1'b1;
                    mem_raddr    = rd_ptr_reg - ADDR_W'(1);
                    wr_pend_next = 1'b1;
                    wr_addr_next = rd_ptr_reg;
                    rd_ptr_next  = rd_ptr_reg - ADDR_W'(1);
                end else if (wr_pend_reg) begin
                    wr_pend_next = 1'b0;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = code_reg;
                    state_next = ST_FINISH;
                end
            end

            ST_RDWAIT: begin
                rcode_next = mem_rdata;
                state_next = ST_FINISH;
            end

            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            wr_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg     <= code_next;
        k_reg        <= k_next;
        pend_idx_reg <= pend_idx_next;
        rd_ptr_reg   <= rd_ptr_next;
        wr_addr_reg  <= wr_addr_next;
        hit_reg      <= hit_next;
        pos_reg      <= pos_next;
        ev_reg       <= ev_next;
        evcode_reg   <= evcode_next;
        rvalid_reg   <= rvalid_next;
        rcode_reg    <= rcode_next;
    end

    always_comb begin
        res.done           = (state_reg == ST_FINISH);
        res.was_present    = hit_reg;
        res.found_position = pos_ext[FOUND_W-1:0];
        res.evicted        = ev_reg;
        res.evicted_code   = evcode_reg;
        res.read_valid     = rvalid_reg;
        res.read_code      = rcode_reg;
        res.list_length    = cnt_ext[LEN_W-1:0];
    end

endmodule

`default_nettype wire
